FILE: hw/rtl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Widths, register indexes, micro-operation codes and the control store of the
// barometer temperature and pressure compensation sequencer.
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int RAW_W      = 24;
   localparam int TEMP_W     = 19;
   localparam int PRESS_W    = 32;
   localparam int COEF_W     = 16;
   localparam int LIMIT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DT_W   = 25;
   localparam int MUL_W  = 26;
   localparam int PROD_W = 2 * MUL_W;
   localparam int BASE_W = TEMP_W + 1;
   localparam int WIDE_W = 40;
   localparam int ACC_W  = 64;
   localparam int STEP_W = 5;

   localparam int C5_SH      = 8;
   localparam int C2_SH      = 16;
   localparam int C1_SH      = 15;
   localparam int SH_T       = 23;
   localparam int SH_OFF     = 7;
   localparam int SH_SENS    = 8;
   localparam int SH_P1      = 21;
   localparam int SH_P2      = 15;
   localparam int SENS_SPLIT = 24;

   localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
   localparam logic signed [TEMP_W-1:0] TEMP_VLOW = TEMP_W'(-1500);

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_SENS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_OFFSET = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_TEMPCO  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_TEMPCO   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TEMP     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SLOPE   = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LIMIT   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LIMIT  = CSR_IDX_W'(7);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DT_C6,
      MUL_DT_C4,
      MUL_DT_C3,
      MUL_BASE_SQ,
      MUL_D1_SLO,
      MUL_D1_SHI
   } mul_op_type;

   typedef enum logic [4:0] {
      ALU_NOP,
      ALU_TRAW,
      ALU_OFF,
      ALU_SENS,
      ALU_TLIM,
      ALU_BASE_LO,
      ALU_FIVE,
      ALU_CORR_LO,
      ALU_BASE_VLO,
      ALU_SEVEN,
      ALU_SUB7,
      ALU_SUB11,
      ALU_ACC_LO,
      ALU_ACC_HI,
      ALU_PSHIFT,
      ALU_PRESS,
      ALU_PLIM
   } alu_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_NOT_LOW,
      BR_NOT_VLOW,
      BR_DONE
   } br_type;

   typedef struct packed {
      mul_op_type        mul_op;
      alu_op_type        alu_op;
      br_type            br;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_PRESS = STEP_W'(14);

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      case (addr)
         STEP_W'(0):  w = '{MUL_DT_C6,   ALU_NOP,      BR_NEXT,     '0};
         STEP_W'(1):  w = '{MUL_DT_C4,   ALU_TRAW,     BR_NEXT,     '0};
         STEP_W'(2):  w = '{MUL_DT_C3,   ALU_OFF,      BR_NEXT,     '0};
         STEP_W'(3):  w = '{MUL_NONE,    ALU_SENS,     BR_NEXT,     '0};
         STEP_W'(4):  w = '{MUL_NONE,    ALU_TLIM,     BR_NEXT,     '0};
         STEP_W'(5):  w = '{MUL_NONE,    ALU_BASE_LO,  BR_NOT_LOW,  STEP_PRESS};
         STEP_W'(6):  w = '{MUL_BASE_SQ, ALU_NOP,      BR_NEXT,     '0};
         STEP_W'(7):  w = '{MUL_NONE,    ALU_FIVE,     BR_NEXT,     '0};
         STEP_W'(8):  w = '{MUL_NONE,    ALU_CORR_LO,  BR_NOT_VLOW, STEP_PRESS};
         STEP_W'(9):  w = '{MUL_NONE,    ALU_BASE_VLO, BR_NEXT,     '0};
         STEP_W'(10): w = '{MUL_BASE_SQ, ALU_NOP,      BR_NEXT,     '0};
         STEP_W'(11): w = '{MUL_NONE,    ALU_SEVEN,    BR_NEXT,     '0};
         STEP_W'(12): w = '{MUL_NONE,    ALU_SUB7,     BR_NEXT,     '0};
         STEP_W'(13): w = '{MUL_NONE,    ALU_SUB11,    BR_NEXT,     '0};
         STEP_W'(14): w = '{MUL_D1_SLO,  ALU_NOP,      BR_NEXT,     '0};
         STEP_W'(15): w = '{MUL_D1_SHI,  ALU_ACC_LO,   BR_NEXT,     '0};
         STEP_W'(16): w = '{MUL_NONE,    ALU_ACC_HI,   BR_NEXT,     '0};
         STEP_W'(17): w = '{MUL_NONE,    ALU_PSHIFT,   BR_NEXT,     '0};
         STEP_W'(18): w = '{MUL_NONE,    ALU_PRESS,    BR_NEXT,     '0};
         STEP_W'(19): w = '{MUL_NONE,    ALU_PLIM,     BR_NEXT,     '0};
         STEP_W'(20): w = '{MUL_NONE,    ALU_NOP,      BR_DONE,     '0};
         default:     w = '{MUL_NONE,    ALU_NOP,      BR_DONE,     '0};
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// The low corrections are skipped at or above 20.00 C of limited temperature,
// the very-low ones at or above -15.00 C; one transaction in flight, the next
// is taken in the cycle after the response is loaded. The control store walks
// one step a cycle, holding at the last step while the previous response waits,
// over one shared 26x26 multiplier. Reset clears history, coefficients to 0 and step limits to 2.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Microcoded second-order temperature and pressure compensation with
// rate limiting of both results.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [bptc_pkg::RAW_W-1:0]               req_raw_temperature,
   input  logic [bptc_pkg::RAW_W-1:0]               req_raw_pressure,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [bptc_pkg::TEMP_W-1:0]       rsp_temp_unfiltered,
   output logic signed [bptc_pkg::TEMP_W-1:0]       rsp_temp_limited,
   output logic signed [bptc_pkg::PRESS_W-1:0]      rsp_press_unfiltered,
   output logic signed [bptc_pkg::PRESS_W-1:0]      rsp_press_limited,
   input  logic                                     csr_wr_en,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int TEMP_W  = bptc_pkg::TEMP_W;
   localparam int PRESS_W = bptc_pkg::PRESS_W;
   localparam int COEF_W  = bptc_pkg::COEF_W;
   localparam int LIMIT_W = bptc_pkg::LIMIT_W;
   localparam int RAW_W   = bptc_pkg::RAW_W;
   localparam int DT_W    = bptc_pkg::DT_W;
   localparam int MUL_W   = bptc_pkg::MUL_W;
   localparam int PROD_W  = bptc_pkg::PROD_W;
   localparam int BASE_W  = bptc_pkg::BASE_W;
   localparam int WIDE_W  = bptc_pkg::WIDE_W;
   localparam int ACC_W   = bptc_pkg::ACC_W;
   localparam int STEP_W  = bptc_pkg::STEP_W;
   localparam int TRAW_W  = PROD_W - bptc_pkg::SH_T;
   localparam int SPLIT   = bptc_pkg::SENS_SPLIT;

   function automatic logic signed [TEMP_W-1:0] limit_temp(
      input logic signed [TEMP_W-1:0] last,
      input logic signed [TEMP_W-1:0] now,
      input logic [LIMIT_W-1:0]       lim
   );
      logic signed [TEMP_W:0] diff;
      logic signed [TEMP_W:0] lim_s;
      logic signed [TEMP_W:0] step_v;
      logic signed [TEMP_W:0] sum_v;
      diff  = (TEMP_W+1)'(now) - (TEMP_W+1)'(last);
      lim_s = $signed({{(TEMP_W+1-LIMIT_W){1'b0}}, lim});
      if (diff > lim_s) begin
         step_v = lim_s;
      end else if (diff < -lim_s) begin
         step_v = -lim_s;
      end else begin
         step_v = diff;
      end
      sum_v = (TEMP_W+1)'(last) + step_v;
      return (last == '0) ? now : sum_v[TEMP_W-1:0];
   endfunction

   function automatic logic signed [PRESS_W-1:0] limit_press(
      input logic signed [PRESS_W-1:0] last,
      input logic signed [PRESS_W-1:0] now,
      input logic [LIMIT_W-1:0]        lim
   );
      logic signed [PRESS_W:0] diff;
      logic signed [PRESS_W:0] lim_s;
      logic signed [PRESS_W:0] step_v;
      logic signed [PRESS_W:0] sum_v;
      diff  = (PRESS_W+1)'(now) - (PRESS_W+1)'(last);
      lim_s = $signed({{(PRESS_W+1-LIMIT_W){1'b0}}, lim});
      if (diff > lim_s) begin
         step_v = lim_s;
      end else if (diff < -lim_s) begin
         step_v = -lim_s;
      end else begin
         step_v = diff;
      end
      sum_v = (PRESS_W+1)'(last) + step_v;
      return (last == '0) ? now : sum_v[PRESS_W-1:0];
   endfunction

   // configuration
   logic [COEF_W-1:0]  c1_ff, c1_in;
   logic [COEF_W-1:0]  c2_ff, c2_in;
   logic [COEF_W-1:0]  c3_ff, c3_in;
   logic [COEF_W-1:0]  c4_ff, c4_in;
   logic [COEF_W-1:0]  c5_ff, c5_in;
   logic [COEF_W-1:0]  c6_ff, c6_in;
   logic [LIMIT_W-1:0] temp_lim_ff, temp_lim_in;
   logic [LIMIT_W-1:0] press_lim_ff, press_lim_in;

   // sequencer
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_out;
   logic              out_free;
   logic              accept;
   bptc_pkg::ucode_type  uc;
   bptc_pkg::mul_op_type mul_op;
   bptc_pkg::alu_op_type alu_op;

   // datapath
   logic signed [DT_W-1:0]    dt_ff, dt_in;
   logic [RAW_W-1:0]          d1_ff, d1_in;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [TRAW_W-1:0]  traw_sum;
   logic signed [WIDE_W-1:0]  sq;
   logic signed [TEMP_W-1:0]  t_raw_ff, t_raw_in;
   logic signed [TEMP_W-1:0]  last_temp_ff, last_temp_in;
   logic signed [WIDE_W-1:0]  off_ff, off_in;
   logic signed [WIDE_W-1:0]  sens_ff, sens_in;
   logic signed [BASE_W-1:0]  base_ff, base_in;
   logic signed [WIDE_W-1:0]  tmp_ff, tmp_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PRESS_W-1:0] p_raw_ff, p_raw_in;
   logic signed [PRESS_W-1:0] last_press_ff, last_press_in;

   logic signed [TEMP_W-1:0]  rsp_t_raw_ff, rsp_t_lim_ff;
   logic signed [PRESS_W-1:0] rsp_p_raw_ff, rsp_p_lim_ff;

   assign req_ready            = !busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_temp_unfiltered  = rsp_t_raw_ff;
   assign rsp_temp_limited     = rsp_t_lim_ff;
   assign rsp_press_unfiltered = rsp_p_raw_ff;
   assign rsp_press_limited    = rsp_p_lim_ff;

   assign accept   = req_valid && !busy_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign uc       = bptc_pkg::ucode_rom(step_ff);
   assign mul_op   = busy_ff ? uc.mul_op : bptc_pkg::MUL_NONE;
   assign alu_op   = busy_ff ? uc.alu_op : bptc_pkg::ALU_NOP;

   always_comb begin
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      c3_in        = c3_ff;
      c4_in        = c4_ff;
      c5_in        = c5_ff;
      c6_in        = c6_ff;
      temp_lim_in  = temp_lim_ff;
      press_lim_in = press_lim_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bptc_pkg::CSR_PRESS_SENS:   c1_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_PRESS_OFFSET: c2_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_SENS_TEMPCO:  c3_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_OFF_TEMPCO:   c4_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_REF_TEMP:     c5_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_TEMP_SLOPE:   c6_in = csr_wdata[COEF_W-1:0];
            bptc_pkg::CSR_TEMP_LIMIT:   temp_lim_in = csr_wdata[LIMIT_W-1:0];
            bptc_pkg::CSR_PRESS_LIMIT:  press_lim_in = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // step counter and branch
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load_out     = 1'b0;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else begin
         case (uc.br)
            bptc_pkg::BR_NEXT: begin
               step_in = step_ff + STEP_W'(1);
            end
            bptc_pkg::BR_NOT_LOW: begin
               step_in = (last_temp_ff >= bptc_pkg::TEMP_REF) ? uc.target
                                                              : step_ff + STEP_W'(1);
            end
            bptc_pkg::BR_NOT_VLOW: begin
               step_in = (last_temp_ff >= bptc_pkg::TEMP_VLOW) ? uc.target
                                                               : step_ff + STEP_W'(1);
            end
            bptc_pkg::BR_DONE: begin
               if (out_free) begin
                  busy_in      = 1'b0;
                  load_out     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
            default: begin
               step_in = step_ff + STEP_W'(1);
            end
         endcase
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mul_op)
         bptc_pkg::MUL_DT_C6: begin
            mul_a = MUL_W'(dt_ff);
            mul_b = $signed({{(MUL_W-COEF_W){1'b0}}, c6_ff});
         end
         bptc_pkg::MUL_DT_C4: begin
            mul_a = MUL_W'(dt_ff);
            mul_b = $signed({{(MUL_W-COEF_W){1'b0}}, c4_ff});
         end
         bptc_pkg::MUL_DT_C3: begin
            mul_a = MUL_W'(dt_ff);
            mul_b = $signed({{(MUL_W-COEF_W){1'b0}}, c3_ff});
         end
         bptc_pkg::MUL_BASE_SQ: begin
            mul_a = MUL_W'(base_ff);
            mul_b = MUL_W'(base_ff);
         end
         bptc_pkg::MUL_D1_SLO: begin
            mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_ff});
            mul_b = $signed({{(MUL_W-SPLIT){1'b0}}, sens_ff[SPLIT-1:0]});
         end
         bptc_pkg::MUL_D1_SHI: begin
            mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_ff});
            mul_b = MUL_W'($signed(sens_ff[WIDE_W-1:SPLIT]));
         end
         default: begin
         end
      endcase
      prod_in = (mul_op != bptc_pkg::MUL_NONE) ? mul_a * mul_b : prod_ff;
   end

   assign traw_sum = $signed(prod_ff[PROD_W-1:bptc_pkg::SH_T]) + TRAW_W'(bptc_pkg::TEMP_REF);
   assign sq       = $signed(prod_ff[WIDE_W-1:0]);

   always_comb begin
      dt_in         = dt_ff;
      d1_in         = d1_ff;
      t_raw_in      = t_raw_ff;
      last_temp_in  = last_temp_ff;
      off_in        = off_ff;
      sens_in       = sens_ff;
      base_in       = base_ff;
      tmp_in        = tmp_ff;
      acc_in        = acc_ff;
      p_raw_in      = p_raw_ff;
      last_press_in = last_press_ff;
      if (accept) begin
         dt_in = $signed({1'b0, req_raw_temperature})
               - $signed({1'b0, c5_ff, {bptc_pkg::C5_SH{1'b0}}});
         d1_in = req_raw_pressure;
      end
      case (alu_op)
         bptc_pkg::ALU_TRAW: begin
            t_raw_in = traw_sum[TEMP_W-1:0];
         end
         bptc_pkg::ALU_OFF: begin
            off_in = $signed({{(WIDE_W-COEF_W-bptc_pkg::C2_SH){1'b0}}, c2_ff,
                              {bptc_pkg::C2_SH{1'b0}}})
                   + $signed(prod_ff[WIDE_W+bptc_pkg::SH_OFF-1:bptc_pkg::SH_OFF]);
         end
         bptc_pkg::ALU_SENS: begin
            sens_in = $signed({{(WIDE_W-COEF_W-bptc_pkg::C1_SH){1'b0}}, c1_ff,
                               {bptc_pkg::C1_SH{1'b0}}})
                    + $signed(prod_ff[WIDE_W+bptc_pkg::SH_SENS-1:bptc_pkg::SH_SENS]);
         end
         bptc_pkg::ALU_TLIM: begin
            last_temp_in = limit_temp(last_temp_ff, t_raw_ff, temp_lim_ff);
         end
         bptc_pkg::ALU_BASE_LO: begin
            base_in = BASE_W'(last_temp_ff) - BASE_W'(bptc_pkg::TEMP_REF);
         end
         bptc_pkg::ALU_FIVE: begin
            tmp_in = (sq <<< 2) + sq;
         end
         bptc_pkg::ALU_CORR_LO: begin
            off_in  = off_ff - (tmp_ff >>> 1);
            sens_in = sens_ff - (tmp_ff >>> 2);
         end
         bptc_pkg::ALU_BASE_VLO: begin
            base_in = BASE_W'(last_temp_ff) - BASE_W'(bptc_pkg::TEMP_VLOW);
         end
         bptc_pkg::ALU_SEVEN: begin
            tmp_in = (sq <<< 3) - sq;
         end
         bptc_pkg::ALU_SUB7: begin
            off_in = off_ff - tmp_ff;
            tmp_in = (sq <<< 3) + (sq <<< 1) + sq;
         end
         bptc_pkg::ALU_SUB11: begin
            sens_in = sens_ff - (tmp_ff >>> 1);
         end
         bptc_pkg::ALU_ACC_LO: begin
            acc_in = ACC_W'(prod_ff);
         end
         bptc_pkg::ALU_ACC_HI: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) <<< SPLIT);
         end
         bptc_pkg::ALU_PSHIFT: begin
            acc_in = (acc_ff >>> bptc_pkg::SH_P1) - ACC_W'(off_ff);
         end
         bptc_pkg::ALU_PRESS: begin
            p_raw_in = acc_ff[PRESS_W+bptc_pkg::SH_P2-1:bptc_pkg::SH_P2];
         end
         bptc_pkg::ALU_PLIM: begin
            last_press_in = limit_press(last_press_ff, p_raw_ff, press_lim_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff         <= '0;
         c2_ff         <= '0;
         c3_ff         <= '0;
         c4_ff         <= '0;
         c5_ff         <= '0;
         c6_ff         <= '0;
         temp_lim_ff   <= bptc_pkg::LIMIT_RESET;
         press_lim_ff  <= bptc_pkg::LIMIT_RESET;
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         last_temp_ff  <= '0;
         last_press_ff <= '0;
      end else begin
         c1_ff         <= c1_in;
         c2_ff         <= c2_in;
         c3_ff         <= c3_in;
         c4_ff         <= c4_in;
         c5_ff         <= c5_in;
         c6_ff         <= c6_in;
         temp_lim_ff   <= temp_lim_in;
         press_lim_ff  <= press_lim_in;
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_temp_ff  <= last_temp_in;
         last_press_ff <= last_press_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      d1_ff    <= d1_in;
      prod_ff  <= prod_in;
      t_raw_ff <= t_raw_in;
      off_ff   <= off_in;
      sens_ff  <= sens_in;
      base_ff  <= base_in;
      tmp_ff   <= tmp_in;
      acc_ff   <= acc_in;
      p_raw_ff <= p_raw_in;
      if (load_out) begin
         rsp_t_raw_ff <= t_raw_ff;
         rsp_t_lim_ff <= last_temp_ff;
         rsp_p_raw_ff <= p_raw_ff;
         rsp_p_lim_ff <= last_press_ff;
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometer compensation block. A directed table
// of register writes and readings is walked first. It covers the reset state,
// slewing down to a true zero, the low and very-low corrections, a zero step
// limit and the field extremes. Randomized calibration phases follow. Every
// response is scored field by field against a behavioral model of the
// compensation and rate limiting, the reset-state readings against fixed values.
// ----------------------------------------------------------------------------
module tb_top;
   import bptc_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int NUM_PHASES    = 10;
   localparam int PHASE_ITEMS   = 103;
   localparam int NUM_ROWS      = 36;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp_raw;
      logic signed [TEMP_W-1:0]  temp_lim;
      logic signed [PRESS_W-1:0] press_raw;
      logic signed [PRESS_W-1:0] press_lim;
   } reading_t;

   typedef enum logic {ROW_WRITE, ROW_READING} row_kind_t;

   typedef struct packed {
      row_kind_t             kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [RAW_W-1:0]      raw_t;
      logic [RAW_W-1:0]      raw_p;
      logic                  typed;
      reading_t              want;
   } plan_row_t;

   localparam reading_t BOOT_READING = '{TEMP_W'(2000), TEMP_W'(2000), '0, '0};

   localparam plan_row_t PLAN [NUM_ROWS] = '{
      '{ROW_READING, '0, '0, 24'h000000, 24'h000000, 1'b1, BOOT_READING},
      '{ROW_READING, '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, BOOT_READING},
      '{ROW_WRITE, CSR_PRESS_SENS,   16'd40127, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_OFFSET, 16'd36924, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_SENS_TEMPCO,  16'd23317, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_OFF_TEMPCO,   16'd23282, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_REF_TEMP,     16'd33464, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_TEMP_SLOPE,   16'd28312, '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_TEMP_LIMIT,   16'hC3FA,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_LIMIT,  16'h3C80,  '0, '0, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9085466, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd8000000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9500000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd7000000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9085466, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd8500000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9100000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9085466, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd6789000, 24'd9085466, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd8569150, 24'd9085466, 1'b0, '0},
      '{ROW_WRITE, CSR_TEMP_LIMIT,   16'h0000,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_LIMIT,  16'hFF00,  '0, '0, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd7000000, 24'd8000000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'd8800000, 24'd9500000, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_SENS,   16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_OFFSET, 16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_SENS_TEMPCO,  16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_OFF_TEMPCO,   16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_REF_TEMP,     16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_TEMP_SLOPE,   16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_TEMP_LIMIT,   16'hFFFF,  '0, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_PRESS_LIMIT,  16'h00FF,  '0, '0, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'h000000, 24'hFFFFFF, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{ROW_READING, '0, '0, 24'h000000, 24'h000000, 1'b0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [RAW_W-1:0]          req_raw_temperature = '0;
   logic [RAW_W-1:0]          req_raw_pressure = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0]  rsp_temp_unfiltered;
   logic signed [TEMP_W-1:0]  rsp_temp_limited;
   logic signed [PRESS_W-1:0] rsp_press_unfiltered;
   logic signed [PRESS_W-1:0] rsp_press_limited;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   logic [COEF_W-1:0]  cal_word [6];
   logic [LIMIT_W-1:0] temp_slew;
   logic [LIMIT_W-1:0] press_slew;
   longint             prev_temp;
   longint             prev_press;

   reading_t awaited_readings [$];
   int       mismatch_count = 0;
   int       quiet_cycles = 0;
   bit       steady = 1'b0;

   baro_pressure_temp_compensation uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_raw_temperature  (req_raw_temperature),
      .req_raw_pressure     (req_raw_pressure),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_temp_unfiltered  (rsp_temp_unfiltered),
      .rsp_temp_limited     (rsp_temp_limited),
      .rsp_press_unfiltered (rsp_press_unfiltered),
      .rsp_press_limited    (rsp_press_limited),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // zero history passes the new value through
   function automatic longint slew(longint last, longint now, longint lim);
      longint delta;
      if (last == 0) return now;
      delta = now - last;
      if (delta > lim) delta = lim;
      if (delta < -lim) delta = -lim;
      return last + delta;
   endfunction

   function automatic reading_t compensate(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
      longint   c1, c2, c3, c4, c5, c6;
      longint   d1, d2, dt, t_raw, t_lim, off, sens, off2, sens2, lo_sq, vlo_sq, p64;
      int       p_trunc;
      reading_t r;
      c1 = cal_word[CSR_PRESS_SENS];
      c2 = cal_word[CSR_PRESS_OFFSET];
      c3 = cal_word[CSR_SENS_TEMPCO];
      c4 = cal_word[CSR_OFF_TEMPCO];
      c5 = cal_word[CSR_REF_TEMP];
      c6 = cal_word[CSR_TEMP_SLOPE];
      d2 = raw_t;
      d1 = raw_p;
      dt = d2 - (c5 << 8);
      t_raw = 2000 + ((dt * c6) >>> 23);
      t_lim = slew(prev_temp, t_raw, temp_slew);
      prev_temp = t_lim;
      off = (c2 << 16) + ((c4 * dt) >>> 7);
      sens = (c1 << 15) + ((c3 * dt) >>> 8);
      off2 = 0;
      sens2 = 0;
      if (t_lim < 2000) begin
         lo_sq = (t_lim - 2000) * (t_lim - 2000);
         off2 = (5 * lo_sq) >>> 1;
         sens2 = (5 * lo_sq) >>> 2;
         if (t_lim < -1500) begin
            vlo_sq = (t_lim + 1500) * (t_lim + 1500);
            off2 += 7 * vlo_sq;
            sens2 += (11 * vlo_sq) >>> 1;
         end
      end
      p64 = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
      p_trunc = p64[31:0];
      prev_press = slew(prev_press, p_trunc, press_slew);
      r.temp_raw = t_raw[TEMP_W-1:0];
      r.temp_lim = t_lim[TEMP_W-1:0];
      r.press_raw = p_trunc;
      r.press_lim = prev_press[PRESS_W-1:0];
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      logic [CSR_DATA_W-1:0] w;
      w = $urandom;
      case ($urandom_range(6))
         0: w[LIMIT_W-1:0] = '0;
         1: w[LIMIT_W-1:0] = '1;
         default: ;
      endcase
      return w;
   endfunction

   // call at a falling edge; leaves the write enable high
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TEMP_LIMIT:  temp_slew = data[LIMIT_W-1:0];
         CSR_PRESS_LIMIT: press_slew = data[LIMIT_W-1:0];
         default:         cal_word[idx] = data;
      endcase
      @(negedge clock);
   endtask

   // call at a falling edge; leaves the request valid high
   task automatic send_reading(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p,
                               logic typed, reading_t want);
      reading_t model;
      while (!steady && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure <= raw_p;
      do @(posedge clock); while (!req_ready);
      model = compensate(raw_t, raw_p);
      awaited_readings.push_back(typed ? want : model);
      @(negedge clock);
   endtask

   // hold off until the block has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) rsp_ready <= steady || ($urandom_range(99) >= 10);

   always @(posedge clock) begin
      reading_t head;
      if (rsp_valid && rsp_ready) begin
         if (awaited_readings.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %0d %0d %0d %0d",
                     $time, rsp_temp_unfiltered, rsp_temp_limited,
                     rsp_press_unfiltered, rsp_press_limited);
            mismatch_count++;
         end else begin
            head = awaited_readings.pop_front();
            check_field("temp_unfiltered", head.temp_raw, rsp_temp_unfiltered);
            check_field("temp_limited", head.temp_lim, rsp_temp_limited);
            check_field("press_unfiltered", head.press_raw, rsp_press_unfiltered);
            check_field("press_limited", head.press_lim, rsp_press_limited);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [RAW_W-1:0] raw_t;
      logic [RAW_W-1:0] raw_p;
      longint           near;
      foreach (cal_word[k]) cal_word[k] = '0;
      temp_slew = LIMIT_RESET;
      press_slew = LIMIT_RESET;
      prev_temp = 0;
      prev_press = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            if (i == 0 || PLAN[i-1].kind != ROW_WRITE) settle();
            write_register(PLAN[i].idx, PLAN[i].wdata);
         end else begin
            if (i > 0 && PLAN[i-1].kind == ROW_WRITE) csr_wr_en <= 1'b0;
            send_reading(PLAN[i].raw_t, PLAN[i].raw_p, PLAN[i].typed, PLAN[i].want);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         steady = (ph == 3);
         write_register(CSR_PRESS_SENS, pick_word());
         write_register(CSR_PRESS_OFFSET, pick_word());
         write_register(CSR_SENS_TEMPCO, pick_word());
         write_register(CSR_OFF_TEMPCO, pick_word());
         write_register(CSR_REF_TEMP, pick_word());
         write_register(CSR_TEMP_SLOPE, pick_word());
         write_register(CSR_TEMP_LIMIT, pick_limit());
         write_register(CSR_PRESS_LIMIT, pick_limit());
         csr_wr_en <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(19))
               0: raw_t = '0;
               1: raw_t = '1;
               2, 3, 4, 5, 6, 7: raw_t = $urandom;
               default: begin
                  // stay near the reference temperature
                  near = longint'(cal_word[CSR_REF_TEMP]) * 256
                         + longint'($urandom_range(2097152)) - 1048576;
                  if (near < 0) near = 0;
                  if (near > 16777215) near = 16777215;
                  raw_t = near[RAW_W-1:0];
               end
            endcase
            case ($urandom_range(19))
               0: raw_p = '0;
               1: raw_p = '1;
               default: raw_p = $urandom;
            endcase
            send_reading(raw_t, raw_p, 1'b0, '0);
         end
      end

      steady = 1'b0;
      settle();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
